// File: rtl/core/sctab_pkg.sv
package sctab_pkg;

   // Table geometry and number formats
   localparam int TABLE_ENTRIES = 256;
   localparam int FRACTION_BITS = 29;
   localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_BITS    = FRACTION_BITS + 1;
   localparam int ANGLE_BITS    = 32;
   localparam int VALUE_BITS    = 31;
   localparam int POS_FRAC_BITS = 16;

   // Scaling by TABLE_ENTRIES/90 through a reciprocal of 90
   localparam int DEG_SPAN    = 90;
   localparam int REM_BITS    = $clog2(2 * DEG_SPAN);
   localparam int DIGIT_BITS  = $clog2(DEG_SPAN);
   localparam int RECIP_SHIFT = 38;
   localparam logic [ANGLE_BITS-1:0] RECIP =
      ANGLE_BITS'((64'd1 << RECIP_SHIFT) / DEG_SPAN);
   localparam int QUOT_BITS = 2 * ANGLE_BITS - RECIP_SHIFT;
   localparam logic [ANGLE_BITS-1:0] COS_OFFSET =
      ANGLE_BITS'(DEG_SPAN) << POS_FRAC_BITS;

   localparam logic [ENTRY_BITS-1:0] UNITY = ENTRY_BITS'(1) << FRACTION_BITS;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = $signed(VALUE_BITS'(UNITY));
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = -VALUE_MAX;

   localparam logic [63:0] Q61_HALF_PI = 64'h3243F6A8885A308D;

   // Pipeline depth
   localparam int SCALE_STAGES  = 4;
   localparam int INTERP_STAGES = 3;
   localparam int PIPE_STAGES   = SCALE_STAGES + INTERP_STAGES;

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [1:0]               quad;
      logic [INDEX_BITS-1:0]    idx;
      logic [POS_FRAC_BITS-1:0] frac;
   } pos_type;

   typedef struct packed {
      logic [SCALE_STAGES-1:0]  scale;
      logic [INTERP_STAGES-1:0] interp;
   } stage_load_type;

   // (a*b) >> 61 for a, b below 2^62; table build only
   function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
      al  = {32'd0, a[31:0]};
      ah  = {32'd0, a[63:32]};
      bl  = {32'd0, b[31:0]};
      bh  = {32'd0, b[63:32]};
      ll  = al * bl;
      lh  = al * bh;
      hl  = ah * bl;
      hh  = ah * bh;
      mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
      lo  = {mid[31:0], ll[31:0]};
      hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
      return (hi << 3) | (lo >> 61);
   endfunction

   // Divide a series term by (2k)(2k+1)
   function automatic logic [63:0] series_div(input logic [63:0] t, input int k);
      logic [63:0] q;
      case (k)
         1:  q = t / 64'd6;
         2:  q = t / 64'd20;
         3:  q = t / 64'd42;
         4:  q = t / 64'd72;
         5:  q = t / 64'd110;
         6:  q = t / 64'd156;
         7:  q = t / 64'd210;
         8:  q = t / 64'd272;
         9:  q = t / 64'd342;
         10: q = t / 64'd420;
         11: q = t / 64'd506;
         12: q = t / 64'd600;
         13: q = t / 64'd702;
         14: q = t / 64'd812;
         15: q = t / 64'd930;
         default: q = t / 64'd1056;
      endcase
      return q;
   endfunction

   // Quarter-wave entry: sin(i*pi/(2*TABLE_ENTRIES)), rounded to nearest
   function automatic logic [ENTRY_BITS-1:0] sine_entry(input int i);
      logic [63:0] x, x2, term, sum;
      x = (Q61_HALF_PI / TABLE_ENTRIES) * 64'(i)
        + ((Q61_HALF_PI % TABLE_ENTRIES) * 64'(i)) / TABLE_ENTRIES;
      x2   = mul_q61(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 16; k++) begin
         term = series_div(mul_q61(term, x2), k);
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return ENTRY_BITS'((sum + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS));
   endfunction

endpackage

// File: rtl/core/sine_cosine_table_interp_unit.sv
// Sine and cosine of a signed 16.16 angle in degrees, returned as signed 2.29
// fixed point. Cosine is taken as the sine of the angle plus 90 degrees, with
// 32-bit wrap. The angle is scaled into quarter-wave table steps, split into
// quadrant, index and fraction, and the result interpolates linearly between
// two entries of a 256-entry quarter-wave sine table (unity closes the top).
// A word is accepted on every clock edge with req_valid high and req_stall
// low; one result word follows for every request word, in order. The unit
// accepts one word per cycle while req_stall is low. Seven register stages sit
// between request and result: four for the scaling (offset and magnitude,
// reciprocal multiply by 1/90, remainder, correction and split) and three
// for the interpolation (table reads, slope multiply, add and sign). The first
// stage loads at the accepting edge. A stall on the result side holds the
// unbroken run of full stages that ends at the output; empty stages still
// fill, so req_stall only rises once the whole pipeline is full and blocked.
module sine_cosine_table_interp_unit
   import sctab_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic signed [ANGLE_BITS-1:0] req_angle,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_value
);

   logic [PIPE_STAGES-1:0] vld_in, vld_ff;
   logic [PIPE_STAGES-1:0] blocked;
   logic [PIPE_STAGES-1:0] load_vec;
   stage_load_type         stage_load;
   pos_type                pos;

   // A stage is blocked when it holds a word and everything after it is
   // blocked; the output stage is blocked by the consumer's stall.
   always_comb begin
      blocked[PIPE_STAGES-1] = vld_ff[PIPE_STAGES-1] & rsp_stall;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         blocked[k] = vld_ff[k] & blocked[k+1];
      end
      load_vec = ~blocked;
   end

   always_comb begin
      stage_load.scale  = load_vec[SCALE_STAGES-1:0];
      stage_load.interp = load_vec[PIPE_STAGES-1 -: INTERP_STAGES];
   end

   // Advance valid bits alongside the data; a stage that loads takes
   // whatever sits in the stage before it, bubble or word.
   always_comb begin
      vld_in[0] = load_vec[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         vld_in[k] = load_vec[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   sctab_scale u_scale (
      .clock  (clock),
      .load   (stage_load),
      .opcode (opcode_type'(req_opcode)),
      .angle  (req_angle),
      .pos    (pos)
   );

   sctab_interp u_interp (
      .clock (clock),
      .load  (stage_load),
      .pos   (pos),
      .value (rsp_value)
   );

   assign req_stall = blocked[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

`ifndef ASSERT_OFF
   // an accepted word always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted word did not enter the first stage");

   // an empty first stage never pushes back on the producer
   a_bubble_no_stall: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> !req_stall)
      else $error("request stalled with an empty first stage");

   // a full pipeline under a result stall must stall the requester
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && rsp_stall) |-> req_stall)
      else $error("full pipeline did not stall the requester");

   // results stay within plus or minus unity
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= VALUE_MAX && rsp_value >= VALUE_MIN))
      else $error("result outside unit range");
`endif

endmodule

// File: rtl/core/sctab_scale.sv
module sctab_scale
   import sctab_pkg::*;
(
   input  logic                         clock,
   input  stage_load_type               load,
   input  opcode_type                   opcode,
   input  logic signed [ANGLE_BITS-1:0] angle,
   output pos_type                      pos
);

   // stage 1: cosine offset, magnitude and sign
   logic [ANGLE_BITS-1:0] turned;
   logic [ANGLE_BITS-1:0] mag1_in, mag1_ff;
   logic                  neg1_in, neg1_ff;

   // stage 2: reciprocal multiply
   logic [2*ANGLE_BITS-1:0] recip_prod;
   logic [QUOT_BITS-1:0]    qe2_in, qe2_ff;
   logic [ANGLE_BITS-1:0]   mag2_ff;
   logic                    neg2_ff;

   // stage 3: remainder
   logic [ANGLE_BITS-1:0] back, diff;
   logic [REM_BITS-1:0]   rem3_in, rem3_ff;
   logic [QUOT_BITS-1:0]  qe3_ff;
   logic                  neg3_ff;

   // stage 4: correct, rebuild and split
   logic                  fix;
   logic [QUOT_BITS-1:0]  quot;
   logic [DIGIT_BITS-1:0] digit;
   logic [ANGLE_BITS-1:0] steps_abs, steps_sgn;
   pos_type               pos_in, pos_ff;

   logic [INDEX_BITS-1:0] step_tbl [DEG_SPAN];

   for (genvar g = 0; g < DEG_SPAN; g++) begin : g_step_tbl
      assign step_tbl[g] = INDEX_BITS'((g * TABLE_ENTRIES) / DEG_SPAN);
   end

   always_comb begin
      turned  = angle + ((opcode == OP_COSINE) ? COS_OFFSET : '0);
      neg1_in = turned[ANGLE_BITS-1];
      mag1_in = neg1_in ? -turned : turned;
   end

   always_comb begin
      recip_prod = (2*ANGLE_BITS)'(mag1_ff) * (2*ANGLE_BITS)'(RECIP);
      qe2_in     = recip_prod[2*ANGLE_BITS-1 -: QUOT_BITS];
   end

   // estimate is low by at most one, so the remainder stays below twice 90
   always_comb begin
      back    = ANGLE_BITS'(qe2_ff) * ANGLE_BITS'(DEG_SPAN);
      diff    = mag2_ff - back;
      rem3_in = diff[REM_BITS-1:0];
   end

   always_comb begin
      fix   = rem3_ff >= REM_BITS'(DEG_SPAN);
      quot  = qe3_ff + QUOT_BITS'(fix);
      digit = fix ? DIGIT_BITS'(rem3_ff - REM_BITS'(DEG_SPAN)) : rem3_ff[DIGIT_BITS-1:0];
      steps_abs = ANGLE_BITS'({quot, step_tbl[digit]});
      steps_sgn = neg3_ff ? -steps_abs : steps_abs;
      pos_in.frac = steps_sgn[POS_FRAC_BITS-1:0];
      pos_in.idx  = steps_sgn[POS_FRAC_BITS +: INDEX_BITS];
      pos_in.quad = steps_sgn[POS_FRAC_BITS + INDEX_BITS +: 2];
   end

   always_ff @(posedge clock) begin
      if (load.scale[0]) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
      if (load.scale[1]) begin
         qe2_ff  <= qe2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
      if (load.scale[2]) begin
         rem3_ff <= rem3_in;
         qe3_ff  <= qe2_ff;
         neg3_ff <= neg2_ff;
      end
      if (load.scale[3]) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// File: rtl/core/sctab_interp.sv
module sctab_interp
   import sctab_pkg::*;
(
   input  logic                         clock,
   input  stage_load_type               load,
   input  pos_type                      pos,
   output logic signed [VALUE_BITS-1:0] value
);

   logic [ENTRY_BITS-1:0] rom_tbl [TABLE_ENTRIES];

   // stage 5: mirror, table reads
   logic                     odd;
   logic [INDEX_BITS-1:0]    idx, nxt;
   logic [ENTRY_BITS-1:0]    upper, lower;
   logic [ENTRY_BITS-1:0]    sep5_in, sep5_ff, lower5_ff;
   logic [POS_FRAC_BITS-1:0] frac5_in, frac5_ff;
   logic                     neg5_ff;

   // stage 6: slope times fraction
   logic [ENTRY_BITS+POS_FRAC_BITS-1:0] slope_prod;
   logic [ENTRY_BITS-1:0]               inc6_in, inc6_ff, lower6_ff;
   logic                                neg6_ff;

   // stage 7: add and apply sign
   logic [ENTRY_BITS-1:0]        total;
   logic [VALUE_BITS-1:0]        mag7;
   logic signed [VALUE_BITS-1:0] value_in, value_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
      assign rom_tbl[g] = sine_entry(g);
   end

   always_comb begin
      odd      = pos.quad[0];
      idx      = odd ? ~pos.idx : pos.idx;
      frac5_in = odd ? ~pos.frac : pos.frac;
      nxt      = idx + INDEX_BITS'(1);
      lower    = rom_tbl[idx];
      upper    = (&idx) ? UNITY : rom_tbl[nxt];
      sep5_in  = upper - lower;
   end

   always_comb begin
      slope_prod = (ENTRY_BITS+POS_FRAC_BITS)'(sep5_ff)
                 * (ENTRY_BITS+POS_FRAC_BITS)'(frac5_ff);
      inc6_in    = slope_prod[POS_FRAC_BITS +: ENTRY_BITS];
   end

   always_comb begin
      total    = lower6_ff + inc6_ff;
      mag7     = VALUE_BITS'(total);
      value_in = $signed(neg6_ff ? -mag7 : mag7);
   end

   always_ff @(posedge clock) begin
      if (load.interp[0]) begin
         sep5_ff   <= sep5_in;
         lower5_ff <= lower;
         frac5_ff  <= frac5_in;
         neg5_ff   <= pos.quad[1];
      end
      if (load.interp[1]) begin
         inc6_ff   <= inc6_in;
         lower6_ff <= lower5_ff;
         neg6_ff   <= neg5_ff;
      end
      if (load.interp[2]) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sctab_pkg::*;

   // Degrees per quadrant and the 16.16 weight of one degree
   localparam int     DEG_QUARTER = 90;
   localparam int     DEG_ONE     = 65536;
   // One whole unit of the 16-bit interpolation fraction
   localparam longint FRAC_SPAN   = 65536;
   // Acceptance to rsp_valid is seven stages; leave a little slack on top
   localparam int     SETTLE_CYCLES = PIPE_STAGES + 4;
   localparam int     REPORT_LIMIT  = 10;

   // One pending result word, with the request that produced it
   typedef struct {
      opcode_type                   op;
      logic signed [ANGLE_BITS-1:0] angle;
      logic signed [VALUE_BITS-1:0] value;
   } sine_word_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_valid  = 1'b0;
   logic                         req_stall;
   logic                         req_opcode = 1'b0;
   logic signed [ANGLE_BITS-1:0] req_angle  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall  = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_value;

   // Quarter-wave sine in 1.29, entry TABLE_ENTRIES is unity
   longint        quarter_wave [0:TABLE_ENTRIES];
   sine_word_type pending_sines [$];
   int            mismatch_count = 0;
   int            sender_idle_pct = 0;
   int            receiver_stall_pct = 0;

   sine_cosine_table_interp_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[sine_cosine_table_interp_unit] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Table and prediction
   // ------------------------------------------------------------------

   // (a*b) >> 61, kept to 64 bits
   function automatic logic [63:0] q61_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[124:61];
   endfunction

   // sin(i*pi/(2*TABLE_ENTRIES)) by a 17-term odd series in Q61, rounded to 1.29
   function automatic longint quarter_wave_entry(input int i);
      logic [63:0] x, x2, term, sum;
      x = (Q61_HALF_PI / 64'(TABLE_ENTRIES)) * 64'(i)
        + ((Q61_HALF_PI % 64'(TABLE_ENTRIES)) * 64'(i)) / 64'(TABLE_ENTRIES);
      x2   = q61_product(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 16; k++) begin
         term = q61_product(term, x2) / 64'((2 * k) * (2 * k + 1));
         // alternate signs of the series
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return longint'((sum + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS));
   endfunction

   // Expected rsp_value for one request word
   function automatic logic signed [VALUE_BITS-1:0] predict_sine(
      input opcode_type op, input logic signed [ANGLE_BITS-1:0] angle);
      logic [ANGLE_BITS-1:0] turned;
      logic [31:0]           pos;
      longint                scaled, frac, lower, rise, v;
      int unsigned           steps, idx, quad;
      // cosine is the sine a quarter turn on, with 32-bit wrap
      turned = angle;
      if (op == OP_COSINE) begin
         turned = turned + (ANGLE_BITS'(DEG_QUARTER) << 16);
      end
      // scale into table steps, quotient truncated toward zero, low 32 bits kept
      scaled = (longint'($signed(turned)) * TABLE_ENTRIES) / DEG_QUARTER;
      pos    = scaled[31:0];
      frac   = pos[15:0];
      steps  = pos >> 16;
      idx    = steps % TABLE_ENTRIES;
      quad   = (steps / TABLE_ENTRIES) % 4;
      // odd quadrants run the table backwards
      if (quad % 2 == 1) begin
         idx  = TABLE_ENTRIES - 1 - idx;
         frac = (FRAC_SPAN - 1) - frac;
      end
      lower = quarter_wave[idx];
      rise  = quarter_wave[idx + 1] - lower;
      v     = lower + (rise * frac) / FRAC_SPAN;
      // lower half of the circle is negative
      if (quad >= 2) begin
         v = -v;
      end
      return v[VALUE_BITS-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stall and in-order checking
   // ------------------------------------------------------------------

   // Redraw the stall every cycle; one assignment per edge
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
      end
   endfunction

   // Take each accepted result word against the oldest pending expectation
   always @(posedge clock) begin
      sine_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sines.size() == 0) begin
            note_failure($sformatf("unexpected result word, value %0d", rsp_value));
         end else begin
            want = pending_sines.pop_front();
            if (rsp_value !== want.value) begin
               note_failure($sformatf("%s angle %h: value expected %0d, got %0d",
                  want.op.name(), want.angle, want.value, rsp_value));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one word, hold it until taken, then maybe idle for a while.
   // Valid is left high when no gap follows, so back-to-back words stream.
   task automatic send_word(input opcode_type op, input logic signed [ANGLE_BITS-1:0] angle);
      sine_word_type w;
      int            gap;
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_angle  <= angle;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      w.op    = op;
      w.angle = angle;
      w.value = predict_sine(op, angle);
      pending_sines.push_back(w);
      gap = 0;
      while (gap < 8 && $urandom_range(0, 99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drop_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (pending_sines.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Full-range noise, plain angles, quadrant edges and the 32-bit extremes
   function automatic logic signed [ANGLE_BITS-1:0] draw_angle();
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return int'($urandom_range(0, 1440 * DEG_ONE)) - 720 * DEG_ONE;
         7, 8: begin
            k = int'($urandom_range(0, 16)) - 8;
            return k * DEG_QUARTER * DEG_ONE + int'($urandom_range(0, 16)) - 8;
         end
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               return 32'sh7FFF_FFFF - int'($urandom_range(0, 4095));
            end
            return 32'sh8000_0000 + int'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Quadrant boundaries, both directions, the top of the table and tiny steps
   task automatic test_quadrant_edges();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_word(OP_SINE,   0);
      send_word(OP_SINE,   90 * DEG_ONE);
      send_word(OP_SINE,   180 * DEG_ONE);
      send_word(OP_SINE,   270 * DEG_ONE);
      send_word(OP_SINE,   360 * DEG_ONE);
      send_word(OP_SINE,   -90 * DEG_ONE);
      send_word(OP_SINE,   -180 * DEG_ONE);
      send_word(OP_SINE,   45 * DEG_ONE);
      send_word(OP_COSINE, 45 * DEG_ONE);
      send_word(OP_COSINE, 0);
      send_word(OP_COSINE, 90 * DEG_ONE);
      send_word(OP_COSINE, -90 * DEG_ONE);
      // just below a quarter turn interpolates towards unity
      send_word(OP_SINE,   90 * DEG_ONE - 1);
      // just past it, the table runs backwards
      send_word(OP_SINE,   90 * DEG_ONE + 1);
      send_word(OP_SINE,   1);
      send_word(OP_SINE,   -1);
      drop_request();
   endtask

   // Angles whose scaled value or cosine offset wraps at 32 bits
   task automatic test_wrapping_angles();
      send_word(OP_SINE,   32'sh7FFF_FFFF);
      send_word(OP_COSINE, 32'sh7FFF_FFFF);
      send_word(OP_SINE,   32'sh8000_0000);
      send_word(OP_COSINE, 32'sh8000_0000);
      send_word(OP_SINE,   32'sh8000_0001);
      send_word(OP_SINE,   32'sh7FFF_0000);
      send_word(OP_COSINE, 32'shFFFF_FFFF);
      send_word(OP_SINE,   32'sh5A00_0000);
      send_word(OP_COSINE, 32'shA5A5_A5A5);
      drop_request();
      wait_until_drained();
   endtask

   // Random stream under one idling setting
   task automatic test_streaming(input int count, input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         send_word(opcode_type'($urandom_range(0, 1)), draw_angle());
      end
      drop_request();
      wait_until_drained();
   endtask

   // Stop offering until the pipeline has fully emptied, then resume
   task automatic test_pause_until_empty();
      sender_idle_pct    = 0;
      receiver_stall_pct = 36;
      repeat (20) begin
         send_word(opcode_type'($urandom_range(0, 1)), draw_angle());
      end
      drop_request();
      wait_until_drained();
      repeat (20) begin
         send_word(opcode_type'($urandom_range(0, 1)), draw_angle());
      end
      drop_request();
      wait_until_drained();
   endtask

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         quarter_wave[i] = quarter_wave_entry(i);
      end
      quarter_wave[TABLE_ENTRIES] = longint'(1) << FRACTION_BITS;

      // Hold reset, then release it once
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_quadrant_edges();
      test_wrapping_angles();
      test_streaming(125, 0, 0);
      test_streaming(125, 51, 0);
      test_streaming(125, 0, 51);
      test_streaming(125, 36, 36);
      test_pause_until_empty();

      // Let any stray word fall out before the verdict
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[sine_cosine_table_interp_unit] OK");
      end else begin
         $display("[sine_cosine_table_interp_unit] ERROR");
      end
      $finish;
   end

endmodule
